[sv/lesd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesd_pkg
// shared types, register codes and fixed-point constants of the langevin step
// ----------------------------------------------------------------------------
package lesd_pkg;

  localparam int UNIFORM_BITS = 16;
  localparam int WORD_W       = 16;
  localparam int VAL_W        = 32;
  localparam int DECAY_W      = 16;
  localparam int GAIN_W       = 24;
  localparam int TSTEP_W      = 24;
  localparam int CFG_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int MUL_W        = 36;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int IQ_DEPTH     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TSTEP = 2'd2;

  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd655;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd9268;
  localparam logic [TSTEP_W-1:0] TSTEP_RST = 24'd655;

  // uniform mapping: q = (w + 1) * 2^32 / (2^UNIFORM_BITS + 1)
  localparam int UNIT_A_W   = UNIFORM_BITS + 1;
  localparam int UNIT_SHIFT = UNIFORM_BITS + 2;
  localparam int UNIT_REM_W = UNIFORM_BITS + 34;
  localparam logic [UNIFORM_BITS:0] UNIT_DEN =
    {1'b1, {(UNIFORM_BITS-1){1'b0}}, 1'b1};
  localparam logic [MUL_W-1:0] UNIT_RECIP =
    MUL_W'((128'd1 << (32 + UNIT_SHIFT)) / UNIT_DEN);
  localparam logic [WORD_W-1:0] WORD_MASK = (UNIFORM_BITS >= WORD_W) ?
    {WORD_W{1'b1}} : WORD_W'((64'd1 << UNIFORM_BITS) - 64'd1);

  localparam logic [MUL_W-1:0] TWO_LN2_Q32 = 36'd5954088944;
  localparam logic [MUL_W-1:0] TWO_PI_Q30  = 36'd6746518852;
  localparam logic [33:0]      ONE_Q30     = 34'd1073741824;

  // cosine series divisors and their reciprocals
  localparam int COS_SHIFT  = 36;
  localparam int COS_STEPS  = 6;
  localparam logic [MUL_W-1:0] RECIP_132 = MUL_W'((64'd1 << COS_SHIFT) / 132);
  localparam logic [MUL_W-1:0] RECIP_90  = MUL_W'((64'd1 << COS_SHIFT) / 90);
  localparam logic [MUL_W-1:0] RECIP_56  = MUL_W'((64'd1 << COS_SHIFT) / 56);
  localparam logic [MUL_W-1:0] RECIP_30  = MUL_W'((64'd1 << COS_SHIFT) / 30);
  localparam logic [MUL_W-1:0] RECIP_12  = MUL_W'((64'd1 << COS_SHIFT) / 12);
  localparam logic [MUL_W-1:0] RECIP_2   = MUL_W'((64'd1 << COS_SHIFT) / 2);

  typedef struct packed {
    logic [WORD_W-1:0] rand_radius_x;
    logic [WORD_W-1:0] rand_angle_x;
    logic [WORD_W-1:0] rand_radius_y;
    logic [WORD_W-1:0] rand_angle_y;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]        elapsed_time;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
  } out_item_t;

  typedef struct packed {
    logic [DECAY_W-1:0] decay;
    logic [GAIN_W-1:0]  gain;
    logic [TSTEP_W-1:0] tstep;
  } coef_t;

  function automatic logic [7:0] cos_div(input logic [2:0] k);
    case (k)
      3'd0:    return 8'd132;
      3'd1:    return 8'd90;
      3'd2:    return 8'd56;
      3'd3:    return 8'd30;
      3'd4:    return 8'd12;
      default: return 8'd2;
    endcase
  endfunction

  function automatic logic [MUL_W-1:0] cos_recip(input logic [2:0] k);
    case (k)
      3'd0:    return RECIP_132;
      3'd1:    return RECIP_90;
      3'd2:    return RECIP_56;
      3'd3:    return RECIP_30;
      3'd4:    return RECIP_12;
      default: return RECIP_2;
    endcase
  endfunction

endpackage

[sv/langevin_euler_step_2d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// langevin_euler_step_2d_top
// two-axis langevin particle, one euler-maruyama step per request
// ----------------------------------------------------------------------------
// the time from push to result varies with the leading-zero count of the two
//   radius uniforms; the core takes no new request before its last result is handed on
// the single shared 36x36 multiplier is used by the 24 log squarings per axis and
//   by the cosine series
// the input queue holds two requests and the output register one result
// reset (synchronous, rst_n low) clears state and queues, loads default coefficients
module langevin_euler_step_2d_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  lesd_pkg::in_item_t                 in_data,
  output logic                               out_empty,
  input  logic                               out_pop,
  output lesd_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [lesd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lesd_pkg::CFG_W-1:0]         cfg_wdata
);

  // coefficient registers; the user must write them only while idle, the block does not enforce it
  lesd_pkg::coef_t coef_r;

  // front to back hand-off
  logic               deq_valid, deq_take;
  lesd_pkg::in_item_t deq_item;

  // back to output register
  logic                res_valid, res_ready;
  lesd_pkg::out_item_t res_item;

  // output register
  logic                ov_r;
  lesd_pkg::out_item_t od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.decay <= lesd_pkg::DECAY_RST;
      coef_r.gain  <= lesd_pkg::GAIN_RST;
      coef_r.tstep <= lesd_pkg::TSTEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lesd_pkg::CFG_DECAY: coef_r.decay <= cfg_wdata[lesd_pkg::DECAY_W-1:0];
        lesd_pkg::CFG_GAIN:  coef_r.gain  <= cfg_wdata[lesd_pkg::GAIN_W-1:0];
        lesd_pkg::CFG_TSTEP: coef_r.tstep <= cfg_wdata[lesd_pkg::TSTEP_W-1:0];
        default: ; // unknown index, ignored
      endcase
    end
  end

  // request queue and word masking
  lesd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .deq_valid (deq_valid),
    .deq_item  (deq_item),
    .deq_take  (deq_take)
  );

  // arithmetic sequencer
  lesd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .deq_valid (deq_valid),
    .deq_item  (deq_item),
    .deq_take  (deq_take),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready)
  );

  // result register frees the core while the consumer stalls
  assign res_ready = !ov_r || out_pop;
  assign out_empty = !ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      ov_r <= 1'b1;
      od_r <= res_item;
    end else if (out_pop) begin
      ov_r <= 1'b0;
    end
  end

  // a finished result always lands in the output register
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> !out_empty)
    else $error("result lost on hand-off");

  // a popped result leaves unless a new one replaces it
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !(res_valid && res_ready)) |=> out_empty)
    else $error("popped result repeated");

  // reset leaves no stale result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible after reset");

endmodule

[sv/lesd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesd_front
// input request queue, masks the uniform words to the configured width
// ----------------------------------------------------------------------------
module lesd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  lesd_pkg::in_item_t in_data,
  output logic              deq_valid,
  output lesd_pkg::in_item_t deq_item,
  input  logic              deq_take
);

  lesd_pkg::in_item_t q_r [lesd_pkg::IQ_DEPTH];
  logic [$clog2(lesd_pkg::IQ_DEPTH)-1:0] wr_r, rd_r;
  logic [$clog2(lesd_pkg::IQ_DEPTH+1)-1:0] cnt_r;
  logic push_ok, take_ok;
  lesd_pkg::in_item_t masked;

  assign in_full   = (cnt_r == ($clog2(lesd_pkg::IQ_DEPTH+1))'(lesd_pkg::IQ_DEPTH));
  assign deq_valid = (cnt_r != '0);
  assign deq_item  = q_r[rd_r];
  assign push_ok   = in_push && !in_full;
  assign take_ok   = deq_take && deq_valid;

  always_comb begin
    masked.rand_radius_x = in_data.rand_radius_x & lesd_pkg::WORD_MASK;
    masked.rand_angle_x  = in_data.rand_angle_x  & lesd_pkg::WORD_MASK;
    masked.rand_radius_y = in_data.rand_radius_y & lesd_pkg::WORD_MASK;
    masked.rand_angle_y  = in_data.rand_angle_y  & lesd_pkg::WORD_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        q_r[wr_r] <= masked;
        wr_r      <= wr_r + 1'b1;
      end
      if (take_ok) rd_r <= rd_r + 1'b1;
      if (push_ok && !take_ok) cnt_r <= cnt_r + 1'b1;
      else if (take_ok && !push_ok) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[sv/lesd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesd_core
// sequencer around one shared multiplier: box-muller sample and euler update
// ----------------------------------------------------------------------------
module lesd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  lesd_pkg::coef_t    coef,
  input  logic               deq_valid,
  input  lesd_pkg::in_item_t deq_item,
  output logic               deq_take,
  output logic               res_valid,
  output lesd_pkg::out_item_t res_item,
  input  logic               res_ready
);

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, G_UR, G_URF, G_LEAD, G_SQI, G_SQF, G_LN, G_LNF, G_SQRT,
    G_UA, G_UAF, G_FOLD, G_X, G_Y, G_CM, G_CD, G_CF, G_ETA, G_ETF,
    A_DV, A_DVF, A_GNF, A_PS, A_PSF, S_FIN, S_DONE
  } state_t;

  state_t state_r, ret_r;
  logic   axis_r;
  lesd_pkg::in_item_t item_r;
  logic [lesd_pkg::MUL_W-1:0]  ma_r, mb_r;
  logic [lesd_pkg::PROD_W-1:0] p_r;
  logic        mneg_r;
  logic [31:0] m_r, u_r, y_r, dv_r;
  logic [4:0]  lead_r, cnt_r, k_r;
  logic [23:0] frac_r;
  logic [39:0] sqv_r, res_r;
  logic [19:0] radius_r;
  logic        neg_r;
  logic [2:0]  ck_r;
  logic signed [33:0] t_r;
  logic signed [31:0] eta_r, vnew_r;
  logic signed [47:0] d1_r;
  logic signed [31:0] vel_r [2];
  logic signed [31:0] pos_r [2];
  logic [31:0] time_r;

  function automatic logic signed [47:0] floor_scale(input logic neg,
                                                     input logic [71:0] prod);
    logic [71:0] rnd;
    logic [47:0] mag;
    rnd = prod + 72'h0FFFF;
    mag = neg ? rnd[63:16] : prod[63:16];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [32:0] abs32(input logic signed [31:0] v);
    logic [32:0] e;
    e = {v[31], v};
    return e[32] ? (~e + 33'd1) : e;
  endfunction

  function automatic logic [31:0] unit_fix(input logic [lesd_pkg::UNIT_A_W-1:0] a,
                                           input logic [71:0] prod);
    logic [33:0] q0, q;
    logic [lesd_pkg::UNIT_REM_W-1:0] num, sub, rem;
    q0  = prod[lesd_pkg::UNIT_SHIFT +: 34];
    num = lesd_pkg::UNIT_REM_W'(a) << 32;
    sub = (lesd_pkg::UNIT_REM_W'(q0) << lesd_pkg::UNIFORM_BITS)
          + lesd_pkg::UNIT_REM_W'(q0);
    rem = num - sub;
    q   = (rem >= lesd_pkg::UNIT_REM_W'(lesd_pkg::UNIT_DEN)) ? q0 + 34'd1 : q0;
    if (q == 34'd0) q = 34'd1;
    if (q > 34'h0_FFFF_FFFF) q = 34'h0_FFFF_FFFF;
    return q[31:0];
  endfunction

  // helper values
  logic [15:0] word_sel;
  logic [lesd_pkg::UNIT_A_W-1:0] unit_a;
  logic [31:0] unit_q;
  logic [32:0] f1, f2, mm;
  logic        fold_neg;
  logic [39:0] sq_bit, sq_trial;
  logic        sq_ge;
  logic [32:0] cq0, cq;
  logic [7:0]  cd;
  logic [40:0] cprod, crem;
  logic signed [33:0] t_new, c_val;
  logic [33:0] c_mag;
  logic [31:0] e_mag;
  logic signed [31:0] eta_new, v_cur, p_cur, vsat, psat;
  logic signed [47:0] fs;
  logic [32:0] tsum;
  logic [29:0] lg;

  always_comb begin
    word_sel = axis_r ? item_r.rand_radius_y : item_r.rand_radius_x;
    if (state_r == G_UA || state_r == G_UAF)
      word_sel = axis_r ? item_r.rand_angle_y : item_r.rand_angle_x;
    unit_a = lesd_pkg::UNIT_A_W'(word_sel) + 1'b1;
    unit_q = unit_fix(unit_a, p_r);
    f1 = u_r[31] ? (33'h1_0000_0000 - {1'b0, u_r}) : {1'b0, u_r};
    fold_neg = f1 > 33'h0_4000_0000;
    f2 = fold_neg ? (33'h0_8000_0000 - f1) : f1;
    mm = p_r[63:31];
    lg = 30'(30'd32 << 24) - ({lead_r, 24'd0} + 30'(frac_r));
    sq_bit   = 40'd1 << {k_r, 1'b0};
    sq_trial = res_r + sq_bit;
    sq_ge    = sqv_r >= sq_trial;
    cq0   = p_r[lesd_pkg::COS_SHIFT +: 33];
    cd    = lesd_pkg::cos_div(ck_r);
    cprod = 41'(cq0) * 41'(cd);
    crem  = 41'(dv_r) - cprod;
    cq    = (crem >= 41'(cd)) ? cq0 + 33'd1 : cq0;
    t_new = $signed(lesd_pkg::ONE_Q30) - $signed({1'b0, cq});
    c_val = neg_r ? -t_r : t_r;
    c_mag = c_val[33] ? 34'(-c_val) : 34'(c_val);
    e_mag = p_r[30 +: 32];
    eta_new = mneg_r ? -$signed(e_mag) : $signed(e_mag);
    v_cur = vel_r[axis_r];
    p_cur = pos_r[axis_r];
    fs    = floor_scale(mneg_r, p_r);
    vsat  = sat32(48'(v_cur) - d1_r + fs);
    psat  = sat32(48'(p_cur) + fs);
    tsum  = {1'b0, time_r} + 33'(coef.tstep);
  end

  assign deq_take  = (state_r == S_IDLE) && deq_valid;
  assign res_valid = (state_r == S_DONE);
  always_comb begin
    res_item.elapsed_time = time_r;
    res_item.pos_x = pos_r[0];
    res_item.pos_y = pos_r[1];
    res_item.vel_x = vel_r[0];
    res_item.vel_y = vel_r[1];
  end

  // shared multiplier, one register after it
  always_ff @(posedge clk) p_r <= ma_r * mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      vel_r[0] <= '0;
      vel_r[1] <= '0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      time_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (deq_valid) begin
            item_r  <= deq_item;
            axis_r  <= 1'b0;
            state_r <= G_UR;
          end
        end
        S_WAIT: state_r <= ret_r;
        G_UR: begin
          ma_r <= lesd_pkg::MUL_W'(unit_a);
          mb_r <= lesd_pkg::UNIT_RECIP;
          ret_r <= G_URF; state_r <= S_WAIT;
        end
        G_URF: begin
          m_r <= unit_q; lead_r <= 5'd31; state_r <= G_LEAD;
        end
        G_LEAD: begin
          if (m_r[31] || lead_r == 5'd0) begin
            cnt_r <= '0; frac_r <= '0; state_r <= G_SQI;
          end else begin
            m_r <= m_r << 1; lead_r <= lead_r - 5'd1;
          end
        end
        G_SQI: begin
          ma_r <= lesd_pkg::MUL_W'(m_r); mb_r <= lesd_pkg::MUL_W'(m_r);
          ret_r <= G_SQF; state_r <= S_WAIT;
        end
        G_SQF: begin
          m_r    <= mm[32] ? mm[32:1] : mm[31:0];
          frac_r <= {frac_r[22:0], mm[32]};
          cnt_r  <= cnt_r + 5'd1;
          state_r <= (cnt_r == 5'd23) ? G_LN : G_SQI;
        end
        G_LN: begin
          ma_r <= lesd_pkg::MUL_W'(lg); mb_r <= lesd_pkg::TWO_LN2_Q32;
          ret_r <= G_LNF; state_r <= S_WAIT;
        end
        G_LNF: begin
          sqv_r <= {p_r[63:32], 8'd0}; res_r <= '0; k_r <= 5'd19;
          state_r <= G_SQRT;
        end
        G_SQRT: begin
          if (sq_ge) begin
            sqv_r <= sqv_r - sq_trial;
            res_r <= (res_r >> 1) + sq_bit;
          end else begin
            res_r <= res_r >> 1;
          end
          if (k_r == 5'd0) begin
            radius_r <= sq_ge ? 20'((res_r >> 1) + sq_bit) : 20'(res_r >> 1);
            state_r  <= G_UA;
          end else begin
            k_r <= k_r - 5'd1;
          end
        end
        G_UA: begin
          ma_r <= lesd_pkg::MUL_W'(unit_a);
          mb_r <= lesd_pkg::UNIT_RECIP;
          ret_r <= G_UAF; state_r <= S_WAIT;
        end
        G_UAF: begin
          u_r <= unit_q; state_r <= G_FOLD;
        end
        G_FOLD: begin
          neg_r <= fold_neg;
          ma_r  <= lesd_pkg::MUL_W'(f2); mb_r <= lesd_pkg::TWO_PI_Q30;
          ret_r <= G_X; state_r <= S_WAIT;
        end
        G_X: begin
          ma_r <= lesd_pkg::MUL_W'(p_r[63:32]);
          mb_r <= lesd_pkg::MUL_W'(p_r[63:32]);
          ret_r <= G_Y; state_r <= S_WAIT;
        end
        G_Y: begin
          y_r <= p_r[61:30]; t_r <= $signed(lesd_pkg::ONE_Q30); ck_r <= '0;
          state_r <= G_CM;
        end
        G_CM: begin
          ma_r <= lesd_pkg::MUL_W'(y_r); mb_r <= lesd_pkg::MUL_W'(t_r[32:0]);
          ret_r <= G_CD; state_r <= S_WAIT;
        end
        G_CD: begin
          dv_r <= p_r[61:30];
          ma_r <= lesd_pkg::MUL_W'(p_r[61:30]);
          mb_r <= lesd_pkg::cos_recip(ck_r);
          ret_r <= G_CF; state_r <= S_WAIT;
        end
        G_CF: begin
          t_r <= t_new;
          if (ck_r == 3'(lesd_pkg::COS_STEPS - 1)) begin
            state_r <= G_ETA;
          end else begin
            ck_r <= ck_r + 3'd1; state_r <= G_CM;
          end
        end
        G_ETA: begin
          mneg_r <= c_val[33];
          ma_r <= lesd_pkg::MUL_W'(radius_r); mb_r <= lesd_pkg::MUL_W'(c_mag);
          ret_r <= G_ETF; state_r <= S_WAIT;
        end
        G_ETF: begin
          eta_r <= eta_new; state_r <= A_DV;
        end
        A_DV: begin
          mneg_r <= v_cur[31];
          ma_r <= lesd_pkg::MUL_W'(abs32(v_cur));
          mb_r <= lesd_pkg::MUL_W'(coef.decay);
          ret_r <= A_DVF; state_r <= S_WAIT;
        end
        A_DVF: begin
          d1_r   <= fs;
          mneg_r <= eta_r[31];
          ma_r <= lesd_pkg::MUL_W'(abs32(eta_r));
          mb_r <= lesd_pkg::MUL_W'(coef.gain);
          ret_r <= A_GNF; state_r <= S_WAIT;
        end
        A_GNF: begin
          vnew_r <= vsat; vel_r[axis_r] <= vsat; state_r <= A_PS;
        end
        A_PS: begin
          mneg_r <= vnew_r[31];
          ma_r <= lesd_pkg::MUL_W'(abs32(vnew_r));
          mb_r <= lesd_pkg::MUL_W'(coef.tstep);
          ret_r <= A_PSF; state_r <= S_WAIT;
        end
        A_PSF: begin
          pos_r[axis_r] <= psat;
          if (!axis_r) begin
            axis_r <= 1'b1; state_r <= G_UR;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          time_r  <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
          state_r <= S_DONE;
        end
        S_DONE: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
